// ===== design/stack_sortable_order_check_defines.svh =====
// assertion macros shared by the stack-sortable order check
// expects signals named clk and rst_n in the scope of use
`ifndef STACK_SORTABLE_ORDER_CHECK_DEFINES_SVH
`define STACK_SORTABLE_ORDER_CHECK_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define SSOC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define SSOC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ssoc_pkg.sv =====
// package for the stack-sortable order check
// sizes, fsm state type and the stack memory request struct; no dependencies
package ssoc_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int ITEM_W    = 11;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  // one bit above the item width: once the expected number passes every
  // possible item it can no longer move, so it never wraps
  localparam int EXP_W     = ITEM_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_LOAD,
    S_EMIT
  } ssoc_state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ITEM_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } stk_req_t;

endpackage

// ===== design/stack_sortable_order_check.sv =====
// Stack-sortable order check, top level.
// Input channel (in_valid / in_stall): one item number per item, in_last_item
// marks the end of a sequence. Result channel (out_valid / out_stall): one
// verdict per sequence, given on its last item, 1 = sortable through one
// side stack.
// Timing: an item is taken in the idle state and checked in the next cycle.
// Every stacked entry popped before an item costs a pop in S_CHECK and a
// stack memory read in S_LOAD that brings up the new top; a pop that
// empties the stack needs no read and skips S_LOAD. This is set by the
// single read port of the stack memory; each entry is popped at most once.
// in_stall stays high until the item is done, so no new item is taken
// before then. A last item then goes to S_EMIT to post its verdict into
// the output register behind out_valid.
// The verdict sits in an output register; the next item is accepted while it
// waits. If a second verdict is ready while the first is still stalled, the
// block holds it and keeps in_stall high until the receiver takes the first.
// Reset (rst_n low, synchronous) empties the stack, sets the expected number
// to one and clears the failure flag; no memory clearing is needed, since
// only entries written in the current sequence are ever read.
`include "stack_sortable_order_check_defines.svh"

module stack_sortable_order_check
  import ssoc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ITEM_W-1:0] in_item_number,
  input  logic              in_last_item,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_verdict
);

  ssoc_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [EXP_W-1:0]  next_exp_r, next_exp_nxt;
  logic              failed_r, failed_nxt;
  logic [ITEM_W-1:0] top_r, top_nxt;
  logic [ITEM_W-1:0] item_r, item_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              verdict_r, verdict_nxt;

  stk_req_t          req;
  logic [ITEM_W-1:0] rd_data;
  logic              accept;
  logic              pop_now;
  logic              slot_free;
  logic [ADDR_W-1:0] below_top;

  ssoc_stack_mem u_mem (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign accept    = in_valid && !in_stall;
  assign pop_now   = (count_r != '0) && ({1'b0, top_r} == next_exp_r);
  assign slot_free = !out_valid_r || !out_stall;
  assign below_top = count_r[ADDR_W-1:0] - ADDR_W'(2);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!failed_r && pop_now) begin
          state_nxt = (count_r > CNT_W'(1)) ? S_LOAD : S_CHECK;
        end else begin
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end
      end
      S_LOAD: begin
        state_nxt = S_CHECK;
      end
      S_EMIT: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    count_nxt     = count_r;
    next_exp_nxt  = next_exp_r;
    failed_nxt    = failed_r;
    top_nxt       = top_r;
    item_nxt      = item_r;
    last_nxt      = last_r;
    verdict_nxt   = verdict_r;
    out_valid_nxt = out_valid_r && out_stall;
    req           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_item_number;
          last_nxt = in_last_item;
        end
      end
      S_CHECK: begin
        if (!failed_r) begin
          priority if (pop_now) begin
            // top leaves; fetch the entry below it
            count_nxt    = count_r - CNT_W'(1);
            next_exp_nxt = next_exp_r + EXP_W'(1);
            req.re       = count_r > CNT_W'(1);
            req.raddr    = below_top;
          end else if ({1'b0, item_r} == next_exp_r) begin
            next_exp_nxt = next_exp_r + EXP_W'(1);
          end else if ((count_r != '0) && (top_r < item_r)) begin
            failed_nxt = 1'b1;
          end else if (count_r >= CNT_W'(MAX_ITEMS)) begin
            failed_nxt = 1'b1;
          end else begin
            // push, keeping the new top in a register
            req.we    = 1'b1;
            req.waddr = count_r[ADDR_W-1:0];
            req.wdata = item_r;
            top_nxt   = item_r;
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      S_LOAD: begin
        top_nxt = rd_data;
      end
      S_EMIT: begin
        // post verdict and start a new sequence
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          verdict_nxt   = !failed_r;
          count_nxt     = '0;
          next_exp_nxt  = EXP_W'(1);
          failed_nxt    = 1'b0;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall    = (state_r != S_IDLE);
    out_valid   = out_valid_r;
    out_verdict = verdict_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      next_exp_r  <= EXP_W'(1);
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      next_exp_r  <= next_exp_nxt;
      failed_r    <= failed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_r     <= top_nxt;
    item_r    <= item_nxt;
    last_r    <= last_nxt;
    verdict_r <= verdict_nxt;
  end

  // checks
  `SSOC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_ITEMS),
    "stack count above capacity")
  `SSOC_ASSERT_NOW(a_expected_nonzero, 1'b1, next_exp_r != '0,
    "expected number reached zero")
  `SSOC_ASSERT_NOW(a_load_nonempty, state_r == S_LOAD, count_r != '0,
    "stack read issued on an empty stack")
  `SSOC_ASSERT_NEXT(a_accept_check, accept, state_r == S_CHECK,
    "accepted item not checked next cycle")
  `SSOC_ASSERT_NEXT(a_emit_resets, (state_r == S_EMIT) && slot_free,
    out_valid && (count_r == '0) && !failed_r && (state_r == S_IDLE),
    "verdict posted without a session restart")

endmodule

// ===== design/ssoc_stack_mem.sv =====
// side stack storage: one write port, one registered read port
// depends on ssoc_pkg for sizes and the request struct
module ssoc_stack_mem
  import ssoc_pkg::*;
(
  input  logic              clk,
  input  stk_req_t          req,
  output logic [ITEM_W-1:0] rd_data
);

  logic [ITEM_W-1:0] mem [MAX_ITEMS];
  logic [ITEM_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for stack_sortable_order_check: directed items, random sessions, then a full stack
// verdicts checked against typed-in values or an in-bench one-stack sort model; uses ssoc_pkg

module tb_top;
  import ssoc_pkg::*;

  localparam int RANDOM_ITEMS   = 420;
  localparam int PHASE_ONE_END  = 160;
  localparam int PHASE_TWO_END  = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 50;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DIR_ROWS       = 26;

  // one directed item, with an optional typed-in verdict for its last item
  typedef struct packed {
    logic [ITEM_W-1:0] item;
    logic              last;
    logic              typed;
    logic              verdict;
  } dir_row_t;

  // value range still to be laid out by the sortable-sequence builder
  typedef struct {
    int lo;
    int hi;
    bit emit;
  } span_t;

  logic              clk;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [ITEM_W-1:0] in_item_number = '0;
  logic              in_last_item   = 1'b0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic              out_verdict;

  // typed-in expectation travelling with the item on the input channel
  logic              row_typed      = 1'b0;
  logic              row_verdict    = 1'b0;

  // order-check model state
  logic [ITEM_W-1:0] model_stack [MAX_ITEMS];
  int                model_depth    = 0;
  int                model_next     = 1;
  bit                model_failed   = 1'b0;

  bit                pending_verdicts[$];
  logic [ITEM_W-1:0] session_seq[$];
  int                live_items     = 0;
  int                err_count      = 0;
  int                quiet_cycles   = 0;
  int                send_idle_pct  = 22;
  int                recv_idle_pct  = 57;
  bit                hold_req       = 1'b0;
  bit                hold_done      = 1'b0;
  int                hold_left      = 0;
  bit                model_has;
  bit                model_verdict;
  bit                want_verdict;

  // directed items: extremes, pop chains, failure, ignored tail, duplicates
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{item: 11'd1,    last: 1'b1, typed: 1'b1, verdict: 1'b1}, // single item leaves directly
    '{item: 11'd2047, last: 1'b1, typed: 1'b1, verdict: 1'b1}, // largest item stays stacked
    '{item: 11'd0,    last: 1'b1, typed: 1'b1, verdict: 1'b1}, // zero never leaves
    '{item: 11'd3,    last: 1'b0, typed: 1'b0, verdict: 1'b0},
    '{item: 11'd1,    last: 1'b0, typed: 1'b0, verdict: 1'b0},
    '{item: 11'd2,    last: 1'b1, typed: 1'b0, verdict: 1'b0},
    '{item: 11'd2,    last: 1'b0, typed: 1'b0, verdict: 1'b0},
    '{item: 11'd3,    last: 1'b0, typed: 1'b0, verdict: 1'b0}, // larger than top: fails
    '{item: 11'd1,    last: 1'b0, typed: 1'b0, verdict: 1'b0}, // ignored after failure
    '{item: 11'd1,    last: 1'b1, typed: 1'b1, verdict: 1'b0},
    '{item: 11'd4,    last: 1'b0, typed: 1'b0, verdict: 1'b0},
    '{item: 11'd3,    last: 1'b0, typed: 1'b0, verdict: 1'b0},
    '{item: 11'd2,    last: 1'b0, typed: 1'b0, verdict: 1'b0},
    '{item: 11'd1,    last: 1'b0, typed: 1'b0, verdict: 1'b0},
    '{item: 11'd5,    last: 1'b1, typed: 1'b0, verdict: 1'b0}, // pops 2, 3, 4 first
    '{item: 11'd2,    last: 1'b0, typed: 1'b0, verdict: 1'b0},
    '{item: 11'd2,    last: 1'b0, typed: 1'b0, verdict: 1'b0}, // duplicate is stacked
    '{item: 11'd1,    last: 1'b1, typed: 1'b0, verdict: 1'b0},
    '{item: 11'd1024, last: 1'b0, typed: 1'b0, verdict: 1'b0},
    '{item: 11'd1,    last: 1'b0, typed: 1'b0, verdict: 1'b0},
    '{item: 11'd2047, last: 1'b1, typed: 1'b0, verdict: 1'b0},
    '{item: 11'd5,    last: 1'b0, typed: 1'b0, verdict: 1'b0},
    '{item: 11'd1,    last: 1'b0, typed: 1'b0, verdict: 1'b0},
    '{item: 11'd4,    last: 1'b0, typed: 1'b0, verdict: 1'b0},
    '{item: 11'd2,    last: 1'b0, typed: 1'b0, verdict: 1'b0},
    '{item: 11'd3,    last: 1'b1, typed: 1'b0, verdict: 1'b0}
  };

  stack_sortable_order_check dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item_number (in_item_number),
    .in_last_item   (in_last_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_verdict    (out_verdict)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one item through the one-stack sort; returns 1 when a verdict is due
  function automatic bit step_order(input logic [ITEM_W-1:0] item, input bit last,
                                    output bit verdict);
    verdict = 1'b0;
    if (!model_failed) begin
      while (model_depth > 0 && int'(model_stack[model_depth-1]) == model_next) begin
        model_depth--;
        model_next++;
      end
      if (int'(item) == model_next) begin
        model_next++;
      end else if (model_depth > 0 && model_stack[model_depth-1] < item) begin
        model_failed = 1'b1;
      end else if (model_depth >= MAX_ITEMS) begin
        model_failed = 1'b1;
      end else begin
        model_stack[model_depth] = item;
        model_depth++;
      end
    end
    if (!last) return 1'b0;
    verdict      = !model_failed;
    model_depth  = 0;
    model_next   = 1;
    model_failed = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input bit got, input bit want);
    $display("tb: mismatch at %0t: %s, got %0b want %0b", $realtime, what, got, want);
    err_count++;
  endtask

  // result check first, then the accepted item feeds the model
  always @(posedge clk) begin
    if (in_valid && !in_stall || out_valid && !out_stall) quiet_cycles = 0;
    else quiet_cycles++;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("verdict with none pending", out_verdict, 1'b0);
        end else begin
          want_verdict = pending_verdicts.pop_front();
          if (out_verdict !== want_verdict)
            report_mismatch("verdict", out_verdict, want_verdict);
        end
      end
      if (in_valid && !in_stall) begin
        live_items++;
        model_has = step_order(in_item_number, in_last_item, model_verdict);
        if (model_has) pending_verdicts.push_back(row_typed ? row_verdict : model_verdict);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles with no item moving on either channel
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // offer one item after a random gap, hold it until taken
  task automatic offer_item(input logic [ITEM_W-1:0] item, input bit last,
                            input bit typed, input bit verdict);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_item_number <= item;
    in_last_item   <= last;
    row_typed      <= typed;
    row_verdict    <= verdict;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_session();
    for (int i = 0; i < session_seq.size(); i++)
      offer_item(session_seq[i], i == session_seq.size() - 1, 1'b0, 1'b0);
  endtask

  // random stack-sortable permutation of 1..n: max splits smaller left, larger right
  task automatic build_sortable(input int n);
    span_t work[$];
    span_t s;
    span_t part;
    int    k;
    session_seq.delete();
    part.lo = 1; part.hi = n; part.emit = 1'b0;
    work.push_back(part);
    while (work.size() > 0) begin
      s = work.pop_back();
      if (s.emit) begin
        session_seq.push_back(11'(s.hi));
      end else if (s.lo <= s.hi) begin
        k = $urandom_range(s.hi, s.lo);
        part.lo = k;    part.hi = s.hi - 1; part.emit = 1'b0; work.push_back(part);
        part.lo = s.hi; part.hi = s.hi;     part.emit = 1'b1; work.push_back(part);
        part.lo = s.lo; part.hi = k - 1;    part.emit = 1'b0; work.push_back(part);
      end
    end
  endtask

  // idle mix by progress; hold-off once when the no-idle phase starts
  task automatic update_phase();
    if (live_items < PHASE_ONE_END) begin
      send_idle_pct = 22; recv_idle_pct = 57;
    end else if (live_items < PHASE_TWO_END) begin
      send_idle_pct = 57; recv_idle_pct = 22;
    end else begin
      send_idle_pct = 0; recv_idle_pct = 0;
      if (!hold_done) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
    end
  endtask

  // main stimulus
  initial begin
    int  n;
    int  a;
    int  b;
    int  kind;
    logic [ITEM_W-1:0] tmp;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++)
      offer_item(dir_tab[r].item, dir_tab[r].last, dir_tab[r].typed, dir_tab[r].verdict);

    // random sessions, mostly well-formed
    while (live_items < RANDOM_ITEMS) begin
      update_phase();
      n    = ($urandom_range(19) == 0) ? $urandom_range(48, 13) : $urandom_range(10, 1);
      kind = $urandom_range(99);
      if (kind < 55) begin
        build_sortable(n);
      end else if (kind < 75) begin
        session_seq.delete();
        for (int v = 1; v <= n; v++) session_seq.push_back(11'(v));
        for (int i = n - 1; i > 0; i--) begin
          a              = $urandom_range(i);
          tmp            = session_seq[i];
          session_seq[i] = session_seq[a];
          session_seq[a] = tmp;
        end
      end else if (kind < 88) begin
        // broken permutation: swap, bad value or duplicate
        build_sortable(n + 1);
        a = $urandom_range(n);
        b = $urandom_range(n);
        case ($urandom_range(2))
          0: begin
            tmp            = session_seq[a];
            session_seq[a] = session_seq[b];
            session_seq[b] = tmp;
          end
          1: begin
            session_seq[a] = 11'($urandom_range(n + 3));
          end
          default: begin
            session_seq[a] = session_seq[b];
          end
        endcase
      end else begin
        // noise over the whole item range
        session_seq.delete();
        for (int i = 0; i < n; i++)
          session_seq.push_back($urandom_range(1) ? 11'($urandom_range(2047))
                                                  : 11'($urandom_range(n + 1)));
      end
      send_session();
    end

    // stack full: exactly 1024 stacked, the next push fails, tail ignored
    update_phase();
    session_seq.delete();
    for (int v = 1025; v >= 2; v--) session_seq.push_back(11'(v));
    session_seq.push_back(11'd0);
    session_seq.push_back(11'd1);
    send_session();

    in_valid <= 1'b0;

    // drain
    while (pending_verdicts.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/ssoc_pkg.sv
design/ssoc_stack_mem.sv
design/stack_sortable_order_check.sv
verif/tb_top.sv
